// ----- rtl/cbd_pkg.sv -----
// Shared types, byte constants and hex helpers for the chunked body decoder.
// No dependencies; used by cbd_step and chunked_body_decoder_core.
package cbd_pkg;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_SKIP1 = 3'd2,
    PH_SKIP2 = 3'd3,
    PH_DONE  = 3'd4
  } phase_e;

  // Narrow control state of the decoder, passed between core and step logic
  typedef struct packed {
    phase_e phase;
    logic   hex_open;
    logic   last_was_cr;
    logic   overflow_seen;
  } ctrl_t;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam ctrl_t CTRL_RESET = '{
    phase:         PH_SIZE,
    hex_open:      1'b1,
    last_was_cr:   1'b0,
    overflow_seen: 1'b0
  };

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    hex_nibble = v[3:0];
  endfunction

endpackage

// ----- rtl/cbd_step.sv -----
// Single-byte step of the chunked body decoder: next state and result item.
// Depends on cbd_pkg.
module cbd_step #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic [7:0]           byte_i,
  input  logic                 restart_i,
  input  cbd_pkg::ctrl_t       ctrl_i,
  input  logic [SIZE_BITS-1:0] size_i,
  input  logic [SIZE_BITS-1:0] left_i,
  output cbd_pkg::ctrl_t       ctrl_o,
  output logic [SIZE_BITS-1:0] size_o,
  output logic [SIZE_BITS-1:0] left_o,
  output logic [7:0]           payload_o,
  output logic                 valid_o,
  output logic                 done_o,
  output logic                 overflow_o
);

  cbd_pkg::ctrl_t       cur_ctrl;
  logic [SIZE_BITS-1:0] cur_size;
  logic [SIZE_BITS-1:0] cur_left;

  // Restart clears everything before this byte is looked at
  always_comb begin
    if (restart_i) begin
      cur_ctrl = cbd_pkg::CTRL_RESET;
      cur_size = '0;
      cur_left = '0;
    end else begin
      cur_ctrl = ctrl_i;
      cur_size = size_i;
      cur_left = left_i;
    end
  end

  // Next state
  always_comb begin
    ctrl_o = cur_ctrl;
    size_o = cur_size;
    left_o = cur_left;
    case (cur_ctrl.phase)
      cbd_pkg::PH_SIZE: begin
        if (cur_ctrl.last_was_cr && (byte_i == cbd_pkg::CHAR_LF)) begin
          size_o              = '0;
          ctrl_o.hex_open     = 1'b1;
          ctrl_o.last_was_cr  = 1'b0;
          if (cur_size == '0) begin
            ctrl_o.phase = cbd_pkg::PH_DONE;
          end else begin
            left_o       = cur_size;
            ctrl_o.phase = cbd_pkg::PH_DATA;
          end
        end else begin
          if (cur_ctrl.hex_open) begin
            if (!cbd_pkg::is_hex(byte_i)) begin
              ctrl_o.hex_open = 1'b0;
            end else if (cur_size[SIZE_BITS-1 -: 4] != 4'd0) begin
              // saturate: another digit would not fit
              size_o               = '1;
              ctrl_o.overflow_seen = 1'b1;
            end else begin
              size_o = {cur_size[SIZE_BITS-5:0], cbd_pkg::hex_nibble(byte_i)};
            end
          end
          ctrl_o.last_was_cr = (byte_i == cbd_pkg::CHAR_CR);
        end
      end
      cbd_pkg::PH_DATA: begin
        left_o = cur_left - SIZE_BITS'(1);
        if (cur_left == SIZE_BITS'(1)) begin
          ctrl_o.phase = cbd_pkg::PH_SKIP1;
        end
      end
      cbd_pkg::PH_SKIP1: ctrl_o.phase = cbd_pkg::PH_SKIP2;
      cbd_pkg::PH_SKIP2: ctrl_o.phase = cbd_pkg::PH_SIZE;
      default:           ctrl_o.phase = cbd_pkg::PH_DONE;
    endcase
  end

  // Result item
  always_comb begin
    valid_o    = (cur_ctrl.phase == cbd_pkg::PH_DATA);
    payload_o  = valid_o ? byte_i : 8'h00;
    done_o     = (ctrl_o.phase == cbd_pkg::PH_DONE);
    overflow_o = ctrl_o.overflow_seen;
  end

endmodule

// ----- rtl/chunked_body_decoder_core.sv -----
// Top level of the chunked HTTP body decoder: input register, step logic,
// result register. Depends on cbd_pkg and cbd_step.
//
// Usage:
//   Feed the raw body bytes of a chunked response on the s_axis channel,
//   one item per byte. s_axis_tuser_i set marks the byte as the first of a
//   new body and clears all decoder state before it is processed.
//   Every input item yields exactly one result item on m_axis: the payload
//   byte (zero when not payload) in tdata and three flags in tuser.
//   An accepted item passes through the input register and then the result
//   register before it is presented on m_axis and can be taken.
//   Throughput: one item per cycle while m_axis_tready_i stays high; the
//   state loop is a hex shift-in or a SIZE_BITS-wide decrement and compare.
//   Stall: when the receiver holds m_axis_tready_i low, the result register
//   holds its item, the input register holds one more, and then
//   s_axis_tready_o drops; nothing is lost or repeated.
//   Reset: rst_ni low empties both registers and returns the decoder to the
//   start of a size line with no overflow seen.
module chunked_body_decoder_core #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tuser_i,   // [0] restart
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] payload_byte
  output logic [2:0] m_axis_tuser_o    // [0] payload_valid [1] body_done [2] size_overflow
);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_restart_q;

  // Decoder state
  cbd_pkg::ctrl_t       ctrl_q, ctrl_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [SIZE_BITS-1:0] left_q, left_d;

  // Result register
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_byte_q;
  logic [2:0] out_flags_q;

  logic       out_load;
  logic       advance;
  logic       in_take;
  logic [7:0] res_payload;
  logic       res_valid;
  logic       res_done;
  logic       res_overflow;

  cbd_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .byte_i     (in_byte_q),
    .restart_i  (in_restart_q),
    .ctrl_i     (ctrl_q),
    .size_i     (size_q),
    .left_i     (left_q),
    .ctrl_o     (ctrl_d),
    .size_o     (size_d),
    .left_o     (left_d),
    .payload_o  (res_payload),
    .valid_o    (res_valid),
    .done_o     (res_done),
    .overflow_o (res_overflow)
  );

  // The result register frees up when empty or being drained this cycle
  assign out_load        = !out_vld_q || m_axis_tready_i;
  assign advance         = in_vld_q && out_load;
  assign s_axis_tready_o = !in_vld_q || out_load;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_q);
    out_vld_d = advance ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_vld_q);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ctrl_q    <= cbd_pkg::CTRL_RESET;
      size_q    <= '0;
      left_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      // commit the step only when its result is actually stored
      if (advance) begin
        ctrl_q <= ctrl_d;
        size_q <= size_d;
        left_q <= left_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q    <= s_axis_tdata_i;
      in_restart_q <= s_axis_tuser_i;
    end
    if (advance) begin
      out_byte_q  <= res_payload;
      out_flags_q <= {res_overflow, res_done, res_valid};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_flags_q;

endmodule

// ----- bench/chunked_body_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for chunked_body_decoder_core: drives raw body bytes,
// predicts every result item in SystemVerilog and checks them in order.
// Depends on cbd_pkg and the decoder RTL only.
module chunked_body_decoder_core_tb;

  localparam int SIZE_W = 32;
  localparam logic [SIZE_W-1:0] SIZE_CEIL = '1;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       payload;
    logic       done;
    logic       overflow;
  } decoded_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_PACED, RX_BLOCKED} rx_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       s_valid = 1'b0;
  logic [7:0] s_data = '0;
  logic       s_user = 1'b0;
  logic       m_tready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;  // [7:0] payload_byte
  logic [2:0] m_axis_tuser_o;  // [0] payload_valid [1] body_done [2] size_overflow

  // Predictor state
  cbd_pkg::phase_e   ph = cbd_pkg::PH_SIZE;
  logic [SIZE_W-1:0] size_acc = '0;
  logic [SIZE_W-1:0] left_in_chunk = '0;
  logic              digits_open = 1'b1;
  logic              saw_cr = 1'b0;
  logic              ovf_seen = 1'b0;

  decoded_t    decoded_q[$];
  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0;
  int unsigned burst_left = 0;
  bit          restart_next = 1'b0;

  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned pace = 0;

  chunked_body_decoder_core #(
    .SIZE_BITS(SIZE_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  // Advance the predicted decoder by one byte and return its result item
  function automatic decoded_t decode_byte(input logic [7:0] b, input logic restart);
    decoded_t r;
    int d;
    r = '0;
    if (restart) begin
      ph = cbd_pkg::PH_SIZE;
      size_acc = '0;
      left_in_chunk = '0;
      digits_open = 1'b1;
      saw_cr = 1'b0;
      ovf_seen = 1'b0;
    end
    case (ph)
      cbd_pkg::PH_SIZE: begin
        if (saw_cr && b == cbd_pkg::CHAR_LF) begin
          digits_open = 1'b1;
          saw_cr = 1'b0;
          if (size_acc == '0) begin
            ph = cbd_pkg::PH_DONE;
          end else begin
            left_in_chunk = size_acc;
            ph = cbd_pkg::PH_DATA;
          end
          size_acc = '0;
        end else begin
          if (digits_open) begin
            d = nibble_of(b);
            if (d < 0) begin
              digits_open = 1'b0;
            end else if (size_acc > (SIZE_CEIL >> 4)) begin
              // saturate; the clipped size is still used as the length
              size_acc = SIZE_CEIL;
              ovf_seen = 1'b1;
            end else begin
              size_acc = {size_acc[SIZE_W-5:0], d[3:0]};
            end
          end
          saw_cr = (b == cbd_pkg::CHAR_CR);
        end
      end
      cbd_pkg::PH_DATA: begin
        r.payload = 1'b1;
        r.data = b;
        left_in_chunk = left_in_chunk - SIZE_W'(1);
        if (left_in_chunk == '0) ph = cbd_pkg::PH_SKIP1;
      end
      cbd_pkg::PH_SKIP1: ph = cbd_pkg::PH_SKIP2;
      cbd_pkg::PH_SKIP2: ph = cbd_pkg::PH_SIZE;
      default:           ph = cbd_pkg::PH_DONE;
    endcase
    r.done = (ph == cbd_pkg::PH_DONE);
    r.overflow = ovf_seen;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("ERROR at %0t ns: %s, expected %0h got %0h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Send one byte; bursts of random length with random gaps between them
  task automatic send_item(input logic [7:0] b);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 4);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= restart_next;
    do @(posedge clk_i); while (!s_axis_tready_o);
    decoded_q.push_back(decode_byte(b, restart_next));
    restart_next = 1'b0;
    burst_left--;
    sent_count++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  // Size line: optional leading zeros, digits, optional extension and stray
  // CR or LF, then the closing CR LF
  task automatic send_size_line(input logic [31:0] sz);
    int top;
    int n;
    logic [7:0] b;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) send_item("0");
    top = 7;
    while (top > 0 && sz[top*4 +: 4] == 4'h0) top--;
    for (int i = top; i >= 0; i--) send_item(hex_char(sz[i*4 +: 4]));
    if ($urandom_range(0, 3) == 0) begin
      send_item(";");
      n = $urandom_range(0, 4);
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        if (b == cbd_pkg::CHAR_CR || b == cbd_pkg::CHAR_LF) b = "=";
        send_item(b);
      end
    end
    case ($urandom_range(0, 9))
      0: send_item(cbd_pkg::CHAR_LF);
      1: begin
        send_item(cbd_pkg::CHAR_CR);
        send_item("x");
      end
      default: ;
    endcase
    send_item(cbd_pkg::CHAR_CR);
    send_item(cbd_pkg::CHAR_LF);
  endtask

  // Digits after a non-hex byte are ignored, bare LF and doubled CR do not
  // close the line, the two bytes after chunk data are skipped unchecked,
  // bytes after done are dropped, and an empty line ends the body at once
  task automatic test_size_line();
    restart_next = 1'b1;
    send_item("0");
    send_item("2");
    send_item("G");
    send_item("1");
    send_item(cbd_pkg::CHAR_LF);
    send_item(cbd_pkg::CHAR_CR);
    send_item(cbd_pkg::CHAR_CR);
    send_item(cbd_pkg::CHAR_LF);
    send_item(8'h00);
    send_item(8'hFF);
    send_item("x");
    send_item("y");
    send_item("0");
    send_item(cbd_pkg::CHAR_CR);
    send_item(cbd_pkg::CHAR_LF);
    send_item("5");
    restart_next = 1'b1;
    send_item(cbd_pkg::CHAR_CR);
    send_item(cbd_pkg::CHAR_LF);
  endtask

  // Saturating size, restart in the middle of a huge chunk, non-hex size line
  task automatic test_overflow();
    restart_next = 1'b1;
    repeat (8) send_item("F");
    send_item("a");
    send_item("b");
    send_item(cbd_pkg::CHAR_CR);
    send_item(cbd_pkg::CHAR_LF);
    send_item(8'h80);
    send_item(8'h7F);
    restart_next = 1'b1;
    send_item("z");
    send_item(cbd_pkg::CHAR_CR);
    send_item(cbd_pkg::CHAR_LF);
    send_item("A");
  endtask

  // Mostly well-formed bodies with random content; the rest huge chunks cut
  // short by a restart, and noise
  task automatic test_random_bodies(input int unsigned n_items);
    int unsigned first;
    int unsigned kind;
    int unsigned n;
    logic [31:0] sz;
    logic [7:0] b;
    first = sent_count;
    while (sent_count - first < n_items) begin
      restart_next = ($urandom_range(0, 19) != 0);
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        n = $urandom_range(0, 4);
        repeat (n) begin
          sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
          send_size_line(sz);
          repeat (sz) send_item(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 7) == 0) begin
            send_item(8'($urandom_range(0, 255)));
            send_item(8'($urandom_range(0, 255)));
          end else begin
            send_item(cbd_pkg::CHAR_CR);
            send_item(cbd_pkg::CHAR_LF);
          end
        end
        send_size_line(32'd0);
        n = $urandom_range(0, 3);
        repeat (n) send_item(8'($urandom_range(0, 255)));
      end else if (kind < 16) begin
        n = $urandom_range(6, 11);
        repeat (n) send_item(hex_char(4'($urandom_range(1, 15))));
        send_item(cbd_pkg::CHAR_CR);
        send_item(cbd_pkg::CHAR_LF);
        n = $urandom_range(1, 4);
        repeat (n) send_item(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 24);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: b = cbd_pkg::CHAR_CR;
            1: b = cbd_pkg::CHAR_LF;
            2: b = hex_char(4'($urandom_range(0, 15)));
            default: b = 8'($urandom_range(0, 255));
          endcase
          send_item(b);
        end
      end
    end
  endtask

  // Receiver ready pattern: switch between open, coin toss, paced and
  // long-stall modes
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
      pace = 0;
    end
    rx_left--;
    pace++;
    case (rx_mode)
      RX_OPEN:  m_tready <= 1'b1;
      RX_COIN:  m_tready <= ($urandom_range(0, 1) == 1);
      RX_PACED: m_tready <= (pace % 3 == 0);
      default:  m_tready <= (pace % 16 == 0);
    endcase
  end

  always @(posedge clk_i) begin : check_result
    decoded_t want;
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("result with nothing pending", 8'h00, m_axis_tdata_o);
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata_o !== want.data)
          report_mismatch("payload_byte", want.data, m_axis_tdata_o);
        if (m_axis_tuser_o[0] !== want.payload)
          report_mismatch("payload_valid", 8'(want.payload), 8'(m_axis_tuser_o[0]));
        if (m_axis_tuser_o[1] !== want.done)
          report_mismatch("body_done", 8'(want.done), 8'(m_axis_tuser_o[1]));
        if (m_axis_tuser_o[2] !== want.overflow)
          report_mismatch("size_overflow", 8'(want.overflow), 8'(m_axis_tuser_o[2]));
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    test_size_line();
    test_overflow();
    test_random_bodies(1000);

    @(negedge clk_i);
    s_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cbd_pkg.sv
rtl/cbd_step.sv
rtl/chunked_body_decoder_core.sv
bench/chunked_body_decoder_core_tb.sv
